>>> design/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared widths, command codes and bus state codes for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  // Size of the write byte buffer.
  localparam int MaxBytes = 16;

  // Field widths.
  localparam int CmdW   = 2;
  localparam int AddrW  = 7;
  localparam int LenW   = 5;
  localparam int SlotW  = 4;
  localparam int ByteW  = 8;
  localparam int PhaseW = 2;
  localparam int BitsW  = 4;
  localparam int StateW = 3;

  // Packed word widths on the stream channels.
  localparam int InDataW  = 32;
  localparam int OutDataW = 16;

  // Command codes carried in the input tuser.
  localparam logic [CmdW-1:0] CMD_TICK     = 2'd0;
  localparam logic [CmdW-1:0] CMD_LOAD     = 2'd1;
  localparam logic [CmdW-1:0] CMD_START_WR = 2'd2;
  localparam logic [CmdW-1:0] CMD_START_RD = 2'd3;

  // Bus state codes.
  localparam logic [StateW-1:0] ST_IDLE    = 3'd0;
  localparam logic [StateW-1:0] ST_START   = 3'd1;
  localparam logic [StateW-1:0] ST_WR_WORD = 3'd2;
  localparam logic [StateW-1:0] ST_RD_ACK  = 3'd3;
  localparam logic [StateW-1:0] ST_RD_WORD = 3'd4;
  localparam logic [StateW-1:0] ST_WR_ACK  = 3'd5;
  localparam logic [StateW-1:0] ST_WR_NACK = 3'd6;
  localparam logic [StateW-1:0] ST_STOP    = 3'd7;

  // Phases of one bit cycle.
  localparam logic [PhaseW-1:0] PH_0 = 2'd0;
  localparam logic [PhaseW-1:0] PH_1 = 2'd1;
  localparam logic [PhaseW-1:0] PH_2 = 2'd2;
  localparam logic [PhaseW-1:0] PH_3 = 2'd3;

  // Bits in one byte on the wire.
  localparam logic [BitsW-1:0] BITS_PER_BYTE = 4'd8;

endpackage

`default_nettype wire

>>> design/i2c_master_bit_sequencer_top.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Each input word carries one command. A tick command advances the I2C bit
// cycle by one quarter phase; load and start commands fill the write buffer
// and launch a write or read transaction. Every input word returns exactly
// one output word with the held SCL and SDA drive-low levels, the busy flag
// and, when a received byte completes on that tick, the byte and its index.
//
// Channels: the s_* group takes commands, the m_* group returns results.
// Pipeline: an accepted word sits in the input stage and is then processed
// into the output register, whose result is offered on m_* until taken.
// Throughput: one word per clock while the output is not stalled, set by the
// single input stage feeding one state update and the output register.
// Reset: rst clears the bus state, phase, counters and held levels; the bus
// lines are released and the block is idle. The write buffer is not cleared.
// Stall: when m_tready is low the output word holds, the input stage holds
// its word, and s_tready drops once that stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer_top (
  input  wire  logic                           clk,
  input  wire  logic                           rst,
  input  wire  logic                           s_tvalid,
  output logic                                 s_tready,
  // sda_in[0], address[7:1], length[12:8], byte_index[16:13],
  // byte_value[24:17], zero fill[31:25]
  input  wire  logic [i2cms_pkg::InDataW-1:0]  s_tdata,
  // command[1:0]
  input  wire  logic [i2cms_pkg::CmdW-1:0]     s_tuser,
  output logic                                 m_tvalid,
  input  wire  logic                           m_tready,
  // scl_low[0], sda_low[1], busy_res[2], read_index[6:3], read_data[14:7],
  // zero fill[15]
  output logic [i2cms_pkg::OutDataW-1:0]       m_tdata,
  // read_valid[0]
  output logic                                 m_tuser
);

  import i2cms_pkg::*;

  // Input stage.
  logic                  in_valid;
  logic [CmdW-1:0]       in_cmd;
  logic                  in_sda;
  logic [AddrW-1:0]      in_addr;
  logic [LenW-1:0]       in_len;
  logic [SlotW-1:0]      in_slot;
  logic [ByteW-1:0]      in_byte;
  logic                  advance;

  // Sequencer state.
  logic [StateW-1:0]     bus_state, bus_state_next;
  logic [PhaseW-1:0]     phase, phase_next;
  logic                  start_pending, start_pending_next;
  logic                  busy_mark, busy_mark_next;
  logic [BitsW-1:0]      bits_left, bits_left_next;
  logic [LenW-1:0]       byte_count, byte_count_next;
  logic [ByteW-1:0]      shift_byte, shift_byte_next;
  logic [ByteW-1:0]      address_rw, address_rw_next;
  logic [LenW-1:0]       write_total, write_total_next;
  logic [LenW-1:0]       read_total, read_total_next;
  logic                  scl_held_low, scl_held_low_next;
  logic                  sda_held_low, sda_held_low_next;
  logic [ByteW-1:0]      write_buffer [MaxBytes];

  // Per-word result.
  logic                  rd_valid_next;
  logic [SlotW-1:0]      rd_index_next;
  logic [ByteW-1:0]      rd_data_next;
  logic [LenW-1:0]       len_sat;
  logic [LenW-1:0]       count_inc;
  logic [ByteW-1:0]      buf_word;
  logic                  load_en;

  // Output register frees when empty or taken; the input stage follows it.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= s_tuser;
      in_sda  <= s_tdata[0];
      in_addr <= s_tdata[7:1];
      in_len  <= s_tdata[12:8];
      in_slot <= s_tdata[16:13];
      in_byte <= s_tdata[24:17];
    end
  end

  // Byte counts above the buffer size saturate.
  assign len_sat   = (in_len > LenW'(MaxBytes)) ? LenW'(MaxBytes) : in_len;
  assign count_inc = byte_count + LenW'(1);
  assign load_en   = in_valid && advance && (in_cmd == CMD_LOAD) && !busy_mark;

  // Write buffer; every 4-bit slot lies inside the buffer.
  always_ff @(posedge clk) begin
    if (load_en) begin
      write_buffer[in_slot] <= in_byte;
    end
  end

  // Registered read of the slot for the next write byte. The count and the
  // buffer stay steady for several words before the ACK phase that uses it.
  always_ff @(posedge clk) begin
    buf_word <= write_buffer[byte_count[SlotW-1:0]];
  end

  // One command applied to the sequencer state.
  always_comb begin
    bus_state_next     = bus_state;
    phase_next         = phase;
    start_pending_next = start_pending;
    busy_mark_next     = busy_mark;
    bits_left_next     = bits_left;
    byte_count_next    = byte_count;
    shift_byte_next    = shift_byte;
    address_rw_next    = address_rw;
    write_total_next   = write_total;
    read_total_next    = read_total;
    scl_held_low_next  = scl_held_low;
    sda_held_low_next  = sda_held_low;
    rd_valid_next      = 1'b0;
    rd_index_next      = '0;
    rd_data_next       = '0;

    if (in_cmd == CMD_TICK) begin
      phase_next = phase + PhaseW'(1);
      unique case (bus_state)
        ST_IDLE: begin
          if (start_pending) begin
            start_pending_next = 1'b0;
            byte_count_next    = '0;
            phase_next         = PH_0;
            bus_state_next     = ST_START;
          end
        end
        ST_START: begin
          if (phase == PH_2) begin
            sda_held_low_next = 1'b1;
          end else if (phase == PH_3) begin
            scl_held_low_next = 1'b1;
            bits_left_next    = BITS_PER_BYTE;
            shift_byte_next   = address_rw;
            bus_state_next    = ST_WR_WORD;
          end
        end
        ST_WR_WORD: begin
          if (phase == PH_0) begin
            sda_held_low_next = !shift_byte[ByteW-1];
            shift_byte_next   = {shift_byte[ByteW-2:0], 1'b0};
            bits_left_next    = bits_left - BitsW'(1);
          end else if (phase == PH_1) begin
            scl_held_low_next = 1'b0;
          end else if (phase == PH_3) begin
            scl_held_low_next = 1'b1;
            if (bits_left == '0) begin
              bus_state_next = ST_RD_ACK;
            end
          end
        end
        ST_RD_ACK: begin
          if (phase == PH_0) begin
            sda_held_low_next = 1'b0;
          end else if (phase == PH_1) begin
            scl_held_low_next = 1'b0;
          end else if (phase == PH_3) begin
            scl_held_low_next = 1'b1;
            priority if (in_sda) begin
              bus_state_next = ST_STOP;
            end else if (byte_count < write_total) begin
              shift_byte_next = (byte_count < LenW'(MaxBytes)) ? buf_word : '0;
              byte_count_next = count_inc;
              bits_left_next  = BITS_PER_BYTE;
              bus_state_next  = ST_WR_WORD;
            end else if (byte_count < read_total) begin
              shift_byte_next = '0;
              bits_left_next  = BITS_PER_BYTE;
              bus_state_next  = ST_RD_WORD;
            end else begin
              bus_state_next = ST_STOP;
            end
          end
        end
        ST_RD_WORD: begin
          if (phase == PH_0) begin
            sda_held_low_next = 1'b0;
          end else if (phase == PH_1) begin
            scl_held_low_next = 1'b0;
          end else if (phase == PH_3) begin
            shift_byte_next   = {shift_byte[ByteW-2:0], in_sda};
            scl_held_low_next = 1'b1;
            bits_left_next    = bits_left - BitsW'(1);
            // Last bit of the byte: report it and pick ACK or NACK.
            if (bits_left == BitsW'(1)) begin
              rd_valid_next   = 1'b1;
              rd_index_next   = byte_count[SlotW-1:0];
              rd_data_next    = {shift_byte[ByteW-2:0], in_sda};
              byte_count_next = count_inc;
              bus_state_next  = (count_inc < read_total) ? ST_WR_ACK : ST_WR_NACK;
            end
          end
        end
        ST_WR_ACK: begin
          if (phase == PH_0) begin
            sda_held_low_next = 1'b1;
          end else if (phase == PH_1) begin
            scl_held_low_next = 1'b0;
          end else if (phase == PH_3) begin
            scl_held_low_next = 1'b1;
            bits_left_next    = BITS_PER_BYTE;
            bus_state_next    = ST_RD_WORD;
          end
        end
        ST_WR_NACK: begin
          if (phase == PH_0) begin
            sda_held_low_next = 1'b0;
          end else if (phase == PH_1) begin
            scl_held_low_next = 1'b0;
          end else if (phase == PH_3) begin
            scl_held_low_next = 1'b1;
            bus_state_next    = ST_STOP;
          end
        end
        ST_STOP: begin
          unique case (phase)
            PH_0: sda_held_low_next = 1'b1;
            PH_1: scl_held_low_next = 1'b0;
            PH_2: sda_held_low_next = 1'b0;
            PH_3: begin
              busy_mark_next = 1'b0;
              bus_state_next = ST_IDLE;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end else if (!busy_mark && (in_cmd != CMD_LOAD)) begin
      // Start commands latch the transfer and mark the block busy.
      if (in_cmd == CMD_START_WR) begin
        address_rw_next  = {in_addr, 1'b0};
        write_total_next = len_sat;
        read_total_next  = '0;
      end else begin
        address_rw_next  = {in_addr, 1'b1};
        write_total_next = '0;
        read_total_next  = len_sat;
      end
      start_pending_next = 1'b1;
      busy_mark_next     = 1'b1;
    end
  end

  // Phase reload on a pending start lands on phase 3 before the increment.
  // The code above sets PH_0 after the increment, matching three plus one.

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_state     <= ST_IDLE;
      phase         <= PH_0;
      start_pending <= 1'b0;
      busy_mark     <= 1'b0;
      bits_left     <= '0;
      byte_count    <= '0;
      shift_byte    <= '0;
      address_rw    <= '0;
      write_total   <= '0;
      read_total    <= '0;
      scl_held_low  <= 1'b0;
      sda_held_low  <= 1'b0;
    end else if (in_valid && advance) begin
      bus_state     <= bus_state_next;
      phase         <= phase_next;
      start_pending <= start_pending_next;
      busy_mark     <= busy_mark_next;
      bits_left     <= bits_left_next;
      byte_count    <= byte_count_next;
      shift_byte    <= shift_byte_next;
      address_rw    <= address_rw_next;
      write_total   <= write_total_next;
      read_total    <= read_total_next;
      scl_held_low  <= scl_held_low_next;
      sda_held_low  <= sda_held_low_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      m_tdata <= {1'b0, rd_data_next, rd_index_next, busy_mark_next,
                  sda_held_low_next, scl_held_low_next};
      m_tuser <= rd_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the I2C master bit sequencer
// Sends command words (ticks, buffer loads, write and read starts) through the
// input stream and keeps its own copy of the bus sequencer, which works out
// the held SCL and SDA levels, the busy flag and any received byte for every
// accepted word. Each output word is compared against the oldest predicted
// one. The test runs short directed cases and then well-formed transfers with
// random content, random ACK/NACK responses and stray commands, under three
// sender and receiver stall mixes.
// ----------------------------------------------------------------------------

module tb_top;
  import i2cms_pkg::*;

  localparam int CycleLimit = 200000;

  // One command word as the sequencer takes it.
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic             sda;
    logic [AddrW-1:0] addr;
    logic [LenW-1:0]  len;
    logic [SlotW-1:0] slot;
    logic [ByteW-1:0] value;
  } bus_cmd_t;

  // One output word: held line levels, busy and the received byte.
  typedef struct packed {
    logic             scl;
    logic             sda;
    logic             busy;
    logic             rd_valid;
    logic [SlotW-1:0] rd_index;
    logic [ByteW-1:0] rd_data;
  } line_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [CmdW-1:0]     s_tuser = CMD_TICK;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;

  i2c_master_bit_sequencer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Predicted output words, oldest first.
  line_word_t levels_due[$];

  int errors = 0;
  int words_sent = 0;
  int cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  // Sequencer copy used for prediction.
  logic [StateW-1:0] sq_state = ST_IDLE;
  logic [PhaseW-1:0] sq_phase = PH_0;
  logic              sq_pending = 1'b0;
  logic              sq_busy = 1'b0;
  logic [BitsW-1:0]  sq_bits = '0;
  logic [LenW-1:0]   sq_count = '0;
  logic [ByteW-1:0]  sq_shift = '0;
  logic [ByteW-1:0]  sq_addr_rw = '0;
  logic [LenW-1:0]   sq_wr_total = '0;
  logic [LenW-1:0]   sq_rd_total = '0;
  logic              sq_scl = 1'b0;
  logic              sq_sda = 1'b0;
  logic [ByteW-1:0]  sq_buf[MaxBytes];

  initial begin
    forever #6 clk = ~clk;
  end

  // Run one quarter of the bit cycle on the sequencer copy.
  task automatic advance_bus(input logic sda_level, inout line_word_t res);
    case (sq_state)
      ST_IDLE: begin
        if (sq_pending) begin
          sq_pending = 1'b0;
          sq_count = '0;
          sq_phase = PH_3;
          sq_state = ST_START;
        end
      end
      ST_START: begin
        if (sq_phase == PH_2) begin
          sq_sda = 1'b1;
        end else if (sq_phase == PH_3) begin
          sq_scl = 1'b1;
          sq_bits = BITS_PER_BYTE;
          sq_shift = sq_addr_rw;
          sq_state = ST_WR_WORD;
        end
      end
      ST_WR_WORD: begin
        if (sq_phase == PH_0) begin
          sq_sda = ~sq_shift[7];
          sq_shift = sq_shift << 1;
          sq_bits = sq_bits - 1'b1;
        end else if (sq_phase == PH_1) begin
          sq_scl = 1'b0;
        end else if (sq_phase == PH_3) begin
          sq_scl = 1'b1;
          if (sq_bits == '0) sq_state = ST_RD_ACK;
        end
      end
      ST_RD_ACK: begin
        if (sq_phase == PH_0) begin
          sq_sda = 1'b0;
        end else if (sq_phase == PH_1) begin
          sq_scl = 1'b0;
        end else if (sq_phase == PH_3) begin
          // A high level here is a NACK from the target.
          if (sda_level) begin
            sq_state = ST_STOP;
          end else if (sq_count < sq_wr_total) begin
            sq_shift = sq_buf[sq_count[SlotW-1:0]];
            sq_count = sq_count + 1'b1;
            sq_bits = BITS_PER_BYTE;
            sq_state = ST_WR_WORD;
          end else if (sq_count < sq_rd_total) begin
            sq_shift = '0;
            sq_bits = BITS_PER_BYTE;
            sq_state = ST_RD_WORD;
          end else begin
            sq_state = ST_STOP;
          end
          sq_scl = 1'b1;
        end
      end
      ST_RD_WORD: begin
        if (sq_phase == PH_0) begin
          sq_sda = 1'b0;
        end else if (sq_phase == PH_1) begin
          sq_scl = 1'b0;
        end else if (sq_phase == PH_3) begin
          sq_shift = {sq_shift[ByteW-2:0], sda_level};
          sq_scl = 1'b1;
          sq_bits = sq_bits - 1'b1;
          if (sq_bits == '0) begin
            res.rd_valid = 1'b1;
            res.rd_index = sq_count[SlotW-1:0];
            res.rd_data = sq_shift;
            sq_count = sq_count + 1'b1;
            sq_state = (sq_count < sq_rd_total) ? ST_WR_ACK : ST_WR_NACK;
          end
        end
      end
      ST_WR_ACK: begin
        if (sq_phase == PH_0) begin
          sq_sda = 1'b1;
        end else if (sq_phase == PH_1) begin
          sq_scl = 1'b0;
        end else if (sq_phase == PH_3) begin
          sq_scl = 1'b1;
          sq_bits = BITS_PER_BYTE;
          sq_state = ST_RD_WORD;
        end
      end
      ST_WR_NACK: begin
        if (sq_phase == PH_0) begin
          sq_sda = 1'b0;
        end else if (sq_phase == PH_1) begin
          sq_scl = 1'b0;
        end else if (sq_phase == PH_3) begin
          sq_scl = 1'b1;
          sq_state = ST_STOP;
        end
      end
      default: begin
        // STOP: SDA goes low, SCL is released, then SDA rises.
        if (sq_phase == PH_0) begin
          sq_sda = 1'b1;
        end else if (sq_phase == PH_1) begin
          sq_scl = 1'b0;
        end else if (sq_phase == PH_2) begin
          sq_sda = 1'b0;
        end else begin
          sq_busy = 1'b0;
          sq_state = ST_IDLE;
        end
      end
    endcase
    sq_phase = sq_phase + 1'b1;
  endtask

  // Apply one accepted command word and queue the output word it causes.
  task automatic predict_levels(input bus_cmd_t w);
    line_word_t res;
    logic [LenW-1:0] len_sat;
    res = '0;
    len_sat = (w.len > LenW'(MaxBytes)) ? LenW'(MaxBytes) : w.len;
    if (w.cmd == CMD_TICK) begin
      advance_bus(w.sda, res);
    end else if (!sq_busy) begin
      if (w.cmd == CMD_LOAD) begin
        sq_buf[w.slot] = w.value;
      end else begin
        sq_addr_rw = {w.addr, (w.cmd == CMD_START_RD)};
        sq_wr_total = (w.cmd == CMD_START_WR) ? len_sat : '0;
        sq_rd_total = (w.cmd == CMD_START_RD) ? len_sat : '0;
        sq_pending = 1'b1;
        sq_busy = 1'b1;
      end
    end
    res.scl = sq_scl;
    res.sda = sq_sda;
    res.busy = sq_busy;
    levels_due.push_back(res);
  endtask

  // Send one command word, with random gaps before it.
  task automatic send_word(input bus_cmd_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= w.cmd;
    s_tdata <= {7'd0, w.value, w.slot, w.len, w.addr, w.sda};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_levels(w);
    words_sent++;
  endtask

  // A command word of the given kind with every field random.
  function automatic bus_cmd_t fill_word(input logic [CmdW-1:0] cmd);
    bus_cmd_t w;
    w.cmd = cmd;
    w.sda = 1'($urandom_range(1));
    w.addr = AddrW'($urandom_range(127));
    w.len = LenW'($urandom_range(31));
    w.slot = SlotW'($urandom_range(15));
    w.value = ByteW'($urandom_range(255));
    return w;
  endfunction

  // A random command other than a tick.
  function automatic logic [CmdW-1:0] stray_cmd();
    case ($urandom_range(2))
      0: return CMD_LOAD;
      1: return CMD_START_WR;
      default: return CMD_START_RD;
    endcase
  endfunction

  // Tick until the transfer has ended, with random target replies and the
  // odd command that must be ignored while busy.
  task automatic tick_until_idle();
    bus_cmd_t w;
    while (sq_busy) begin
      if ($urandom_range(99) < 8) begin
        w = fill_word(stray_cmd());
      end else begin
        w = fill_word(CMD_TICK);
        if (sq_state == ST_RD_ACK) w.sda = ($urandom_range(99) < 12);
      end
      send_word(w);
    end
  endtask

  task automatic run_transfer(input logic rd, input logic [AddrW-1:0] addr,
                              input logic [LenW-1:0] len);
    bus_cmd_t w;
    w = fill_word(rd ? CMD_START_RD : CMD_START_WR);
    w.addr = addr;
    w.len = len;
    send_word(w);
    tick_until_idle();
  endtask

  // Ticks with no transfer pending only move the phase.
  task automatic test_idle_ticks();
    repeat (4) send_word(fill_word(CMD_TICK));
  endtask

  // Fill every buffer slot, with both byte extremes among them.
  task automatic test_buffer_load();
    bus_cmd_t w;
    for (int i = 0; i < MaxBytes; i++) begin
      w = fill_word(CMD_LOAD);
      w.slot = SlotW'(i);
      if (i == 0) w.value = 8'h00;
      if (i == MaxBytes - 1) w.value = 8'hFF;
      send_word(w);
    end
  endtask

  // Zero-length read with every command kind sent while busy, then short
  // write and read transfers.
  task automatic test_short_transfers();
    bus_cmd_t w;
    w = fill_word(CMD_START_RD);
    w.addr = 7'h7F;
    w.len = '0;
    send_word(w);
    send_word(fill_word(CMD_LOAD));
    send_word(fill_word(CMD_START_WR));
    send_word(fill_word(CMD_START_RD));
    tick_until_idle();
    run_transfer(1'b0, 7'h00, 5'd1);
    run_transfer(1'b1, 7'h55, 5'd2);
  endtask

  // Random transfers separated by idle ticks and loads; mostly short lengths,
  // a few at or above the buffer size.
  task automatic test_mixed_traffic(input int budget);
    int stop_at;
    int pick;
    logic [LenW-1:0] len;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      repeat ($urandom_range(3)) send_word(fill_word(CMD_TICK));
      if ($urandom_range(9) == 0) send_word(fill_word(CMD_LOAD));
      pick = $urandom_range(99);
      if (pick < 70) len = LenW'($urandom_range(3));
      else if (pick < 93) len = LenW'($urandom_range(8, 4));
      else len = LenW'($urandom_range(31, 16));
      run_transfer(1'($urandom_range(1)), AddrW'($urandom_range(127)), len);
    end
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each output word with the oldest prediction.
  always @(posedge clk) begin
    line_word_t got;
    line_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.scl = m_tdata[0];
      got.sda = m_tdata[1];
      got.busy = m_tdata[2];
      got.rd_valid = m_tuser;
      got.rd_index = m_tdata[6:3];
      got.rd_data = m_tdata[14:7];
      if (levels_due.size() == 0) begin
        if (errors < 10) $display("tb_top: output word with none predicted");
        errors++;
      end else begin
        want = levels_due.pop_front();
        if (got !== want) begin
          if (errors < 10)
            $display({"tb_top: mismatch: want scl %0d sda %0d busy %0d valid %0d ",
                      "idx %0d data %02h, got scl %0d sda %0d busy %0d valid %0d ",
                      "idx %0d data %02h"},
                     want.scl, want.sda, want.busy, want.rd_valid, want.rd_index,
                     want.rd_data, got.scl, got.sda, got.busy, got.rd_valid,
                     got.rd_index, got.rd_data);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct = 13;
    recv_stall_pct = 52;
    test_idle_ticks();
    test_buffer_load();
    test_short_transfers();
    test_mixed_traffic(170);

    send_gap_pct = 52;
    recv_stall_pct = 13;
    test_mixed_traffic(250);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_mixed_traffic(250);

    s_tvalid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
